[rtl/miller_rabin_primality_defines.svh]
// assertion macros for the port-level checker
`ifndef MILLER_RABIN_PRIMALITY_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define MRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mrp_pkg.sv]
// shared types and constants for the miller-rabin primality block
package mrp_pkg;

    localparam int VALUE_WIDTH_DEF = 63;
    localparam int ROUNDS_DEF      = 2;
    localparam int FIRST_PRIME     = 2;

    // sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_POW_CHECK,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SQR_GO,
        ST_SQR_WAIT,
        ST_TEST,
        ST_SQT_GO,
        ST_SQT_WAIT,
        ST_STEP_TEST,
        ST_RESULT
    } mrp_state_t;

    // operations of the shared modular unit
    typedef enum logic {
        UOP_REDUCE,
        UOP_MUL
    } mrp_uop_t;

    // command word to the modular unit
    typedef struct packed {
        logic     start;
        mrp_uop_t op;
    } mrp_uctrl_t;

endpackage

[rtl/miller_rabin_primality.sv]
// top level of the miller-rabin primality tester
//
// Tests one candidate word against ROUNDS witness bases and returns one result
// word. The handshake accepts a word only while the block is idle; a result may
// still wait in the output register while the next candidate is taken. Zero,
// one and even candidates, and two, which gives prime, go straight to the
// result state and raise out_valid once the output register is free. Any other
// candidate first strips the factors of two from p-1, then for each base runs a
// reduction of the base mod p, a square-and-multiply over the odd part q with at
// most two modular products per bit of q, and up to k-1 further squarings.
// Every modular product goes through one shared shift-add unit that retires one
// multiplier bit per cycle.
module miller_rabin_primality
    import mrp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int ROUNDS      = ROUNDS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] candidate,
    input  logic [VALUE_WIDTH-1:0] base_first,
    input  logic [VALUE_WIDTH-1:0] base_second,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_probable_prime
);

    localparam int W  = VALUE_WIDTH;
    localparam int KW = $clog2(VALUE_WIDTH);

    mrp_state_t    state_reg, state_next;

    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  base0_reg, base0_next;
    logic [W-1:0]  base1_reg, base1_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] sq_left_reg, sq_left_next;
    logic          round_reg, round_next;
    logic          verdict_reg, verdict_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_prime_reg, out_prime_next;

    mrp_uctrl_t    uctrl;
    logic [W-1:0]  u_a;
    logic [W-1:0]  u_b;
    logic          u_done;
    logic [W-1:0]  u_res;

    logic          in_take;
    logic          out_free;
    logic [W-1:0]  pm1;
    logic          trivial;
    logic          round_last;
    logic          t_is_one;
    logic          t_is_pm1;

    mrp_modmul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (uctrl),
        .a     (u_a),
        .b     (u_b),
        .m     (p_reg),
        .done  (u_done),
        .res   (u_res)
    );

    // shared status terms
    always_comb
    begin
        in_take    = in_valid && !in_stall;
        out_free   = !out_valid_reg || !out_stall;
        pm1        = p_reg - W'(1);
        trivial    = !candidate[0] || (candidate == W'(1));
        round_last = (round_reg == 1'(ROUNDS - 1));
        t_is_one   = (acc_reg == W'(1));
        t_is_pm1   = (acc_reg == pm1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = trivial ? ST_RESULT : ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (q_reg[0])
                begin
                    state_next = ST_RED_GO;
                end
            end
            ST_RED_GO:    state_next = ST_RED_WAIT;
            ST_RED_WAIT:
            begin
                if (u_done)
                begin
                    state_next = ST_POW_CHECK;
                end
            end
            ST_POW_CHECK:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_TEST;
                end
                else if (e_reg[0])
                begin
                    state_next = ST_MUL_GO;
                end
                else
                begin
                    state_next = ST_SQR_GO;
                end
            end
            ST_MUL_GO:    state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (u_done)
                begin
                    state_next = ST_SQR_GO;
                end
            end
            ST_SQR_GO:    state_next = ST_SQR_WAIT;
            ST_SQR_WAIT:
            begin
                if (u_done)
                begin
                    state_next = ST_POW_CHECK;
                end
            end
            ST_TEST:
            begin
                if (t_is_one || t_is_pm1)
                begin
                    state_next = round_last ? ST_RESULT : ST_RED_GO;
                end
                else if (sq_left_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SQT_GO;
                end
            end
            ST_SQT_GO:    state_next = ST_SQT_WAIT;
            ST_SQT_WAIT:
            begin
                if (u_done)
                begin
                    state_next = ST_STEP_TEST;
                end
            end
            ST_STEP_TEST:
            begin
                if (t_is_pm1)
                begin
                    state_next = round_last ? ST_RESULT : ST_RED_GO;
                end
                else if (sq_left_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SQT_GO;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // unit commands and handshake outputs
    always_comb
    begin
        uctrl.start = 1'b0;
        uctrl.op    = UOP_MUL;
        u_a         = acc_reg;
        u_b         = acc_reg;
        case (state_reg)
            ST_RED_GO:
            begin
                uctrl.start = 1'b1;
                uctrl.op    = UOP_REDUCE;
                u_a         = round_reg ? base1_reg : base0_reg;
            end
            ST_MUL_GO:
            begin
                uctrl.start = 1'b1;
                u_b         = x_reg;
            end
            ST_SQR_GO:
            begin
                uctrl.start = 1'b1;
                u_a         = x_reg;
                u_b         = x_reg;
            end
            ST_SQT_GO:
            begin
                uctrl.start = 1'b1;
            end
            default:
            begin
                uctrl.start = 1'b0;
            end
        endcase
        in_stall = (state_reg != ST_IDLE);
    end

    // datapath next values
    always_comb
    begin
        p_next         = p_reg;
        base0_next     = base0_reg;
        base1_next     = base1_reg;
        q_next         = q_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        sq_left_next   = sq_left_reg;
        round_next     = round_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_prime_next = out_prime_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    p_next       = candidate;
                    base0_next   = base_first;
                    base1_next   = base_second;
                    q_next       = candidate - W'(1);
                    k_next       = '0;
                    round_next   = 1'b0;
                    verdict_next = (candidate == W'(FIRST_PRIME));
                end
            end
            ST_SPLIT:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
            end
            ST_RED_WAIT:
            begin
                if (u_done)
                begin
                    x_next   = u_res;
                    acc_next = W'(1);
                    e_next   = q_reg;
                end
            end
            ST_POW_CHECK:
            begin
                sq_left_next = k_reg - KW'(1);
            end
            ST_MUL_WAIT:
            begin
                if (u_done)
                begin
                    acc_next = u_res;
                end
            end
            ST_SQR_WAIT:
            begin
                if (u_done)
                begin
                    x_next = u_res;
                    e_next = e_reg >> 1;
                end
            end
            ST_TEST:
            begin
                if (t_is_one || t_is_pm1)
                begin
                    verdict_next = 1'b1;
                    round_next   = 1'b1;
                end
                else if (sq_left_reg == '0)
                begin
                    verdict_next = 1'b0;
                end
            end
            ST_SQT_WAIT:
            begin
                if (u_done)
                begin
                    acc_next     = u_res;
                    sq_left_next = sq_left_reg - KW'(1);
                end
            end
            ST_STEP_TEST:
            begin
                if (t_is_pm1)
                begin
                    verdict_next = 1'b1;
                    round_next   = 1'b1;
                end
                else if (sq_left_reg == '0)
                begin
                    verdict_next = 1'b0;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = verdict_reg;
                end
            end
            default:
            begin
                verdict_next = verdict_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        base0_reg     <= base0_next;
        base1_reg     <= base1_next;
        q_reg         <= q_next;
        e_reg         <= e_next;
        acc_reg       <= acc_next;
        x_reg         <= x_next;
        k_reg         <= k_next;
        sq_left_reg   <= sq_left_next;
        round_reg     <= round_next;
        verdict_reg   <= verdict_next;
        out_prime_reg <= out_prime_next;
    end

    assign out_valid         = out_valid_reg;
    assign is_probable_prime = out_prime_reg;

endmodule

[rtl/mrp_modmul.sv]
// shared bit-serial modular unit: a mod m, and a*b mod m for a, b below m
module mrp_modmul
    import mrp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrp_uctrl_t             ctrl,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    input  logic [VALUE_WIDTH-1:0] m,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] res
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    mrp_uop_t      op_reg, op_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W:0]    acc_sum;
    logic [W:0]    acc_add;
    logic [W:0]    x_dbl;
    logic [W:0]    x_red;
    logic [W:0]    acc_sh;
    logic [W:0]    acc_shr;

    // compare-subtract paths, each input stays below twice the modulus
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + {1'b0, x_reg};
        acc_add = (acc_sum >= {1'b0, m_reg}) ? acc_sum - {1'b0, m_reg} : acc_sum;
        x_dbl   = {x_reg, 1'b0};
        x_red   = (x_dbl >= {1'b0, m_reg}) ? x_dbl - {1'b0, m_reg} : x_dbl;
        acc_sh  = {acc_reg, y_reg[W-1]};
        acc_shr = (acc_sh >= {1'b0, m_reg}) ? acc_sh - {1'b0, m_reg} : acc_sh;
    end

    // one multiplier bit or one dividend bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            acc_next  = '0;
            x_next    = a;
            y_next    = (ctrl.op == UOP_MUL) ? b : a;
            m_next    = m;
            cnt_next  = CW'(W);
        end
        else if (busy_reg)
        begin
            case (op_reg)
                UOP_MUL:
                begin
                    if (y_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (y_reg[0])
                        begin
                            acc_next = acc_add[W-1:0];
                        end
                        x_next = x_red[W-1:0];
                        y_next = y_reg >> 1;
                    end
                end
                UOP_REDUCE:
                begin
                    acc_next = acc_shr[W-1:0];
                    y_next   = y_reg << 1;
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= UOP_REDUCE;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

[rtl/mrp_checker.sv]
// port-level checks for the miller-rabin primality block, bound to the top level
`include "miller_rabin_primality_defines.svh"

module mrp_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic is_probable_prime
);

    // a held result word keeps its value
    `MRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(is_probable_prime), "result word changed while stalled")

    // the block is busy right after it takes a word
    `MRP_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input not stalled after a word was taken")

    // a new result only appears at the end of a test
    `MRP_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result appeared while idle")

    // finishing a test frees the input side at once
    `MRP_ASSERT_NOW(a_idle_on_result, $rose(out_valid), !in_stall, "input still stalled after result")

endmodule

bind miller_rabin_primality mrp_checker u_mrp_checker (.*);

[test/miller_rabin_primality_test.sv]
// testbench for the miller-rabin primality block, with directed and random words and a built-in predictor
module miller_rabin_primality_test
    import mrp_pkg::*;
();

    localparam int VW = VALUE_WIDTH_DEF;
    typedef logic [VW-1:0] value_t;

    localparam value_t ALL_ONES    = '1;
    localparam value_t EVEN_TOP    = ALL_ONES - 63'd1;
    localparam value_t MERSENNE_61 = 63'h1FFF_FFFF_FFFF_FFFF;
    localparam value_t TOP_PRIME   = 63'd9223372036854775783;

    logic   clk               = 1'b0;
    logic   rst_n             = 1'b0;
    logic   in_valid          = 1'b0;
    logic   in_stall;
    value_t candidate         = '0;
    value_t base_first        = '0;
    value_t base_second       = '0;
    logic   out_valid;
    logic   out_stall         = 1'b0;
    logic   is_probable_prime;

    // verdicts still owed by the block, oldest first
    bit expected_verdicts[$];
    int verdict_errors = 0;
    int holdoff_cycles = 0;
    int burst_left     = 0;

    miller_rabin_primality dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .candidate         (candidate),
        .base_first        (base_first),
        .base_second       (base_second),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .is_probable_prime (is_probable_prime)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // (x * y) mod m, shift-add with conditional subtract, as the datapath does it
    function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        x = x % m;
        y = y % m;
        while (y != 0)
        begin
            if (y[0])
            begin
                acc = acc + x;
                if (acc >= m)
                    acc = acc - m;
            end
            y = y >> 1;
            x = x << 1;
            if (x >= m)
                x = x - m;
        end
        return acc;
    endfunction

    // x^e mod m by square-and-multiply
    function automatic logic [63:0] mod_power(logic [63:0] x, logic [63:0] e,
                                              logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        x = x % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_product(acc, x, m);
            e = e >> 1;
            x = mod_product(x, x, m);
        end
        return acc;
    endfunction

    // one witness round over p - 1 = q * 2^k
    function automatic bit witness_round_passes(logic [63:0] base, logic [63:0] p,
                                                logic [63:0] q, int k);
        logic [63:0] t;
        logic [63:0] p_minus_one;
        p_minus_one = p - 64'd1;
        t = mod_power(base % p, q, p);
        if (t == 64'd1 || t == p_minus_one)
            return 1'b1;
        for (int i = 1; i < k; i++)
        begin
            t = mod_product(t, t, p);
            if (t == p_minus_one)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // expected verdict for one word
    function automatic bit primality_verdict(value_t cand, value_t b1, value_t b2);
        logic [63:0] p;
        logic [63:0] q;
        int          k;
        p = 64'(cand);
        if (p == 64'(FIRST_PRIME))
            return 1'b1;
        if (p < 64'(FIRST_PRIME) || !p[0])
            return 1'b0;
        q = p - 64'd1;
        k = 0;
        while (!q[0] && k < 64)
        begin
            q = q >> 1;
            k++;
        end
        if (!witness_round_passes(64'(b1), p, q, k))
            return 1'b0;
        if (ROUNDS_DEF > 1 && !witness_round_passes(64'(b2), p, q, k))
            return 1'b0;
        return 1'b1;
    endfunction

    // random odd value with its top bit at position width-1
    function automatic value_t random_odd(int width);
        logic [63:0] r;
        value_t      v;
        r = {$urandom, $urandom};
        v = r[VW-1:0] >> (VW - width);
        v[width-1] = 1'b1;
        v[0] = 1'b1;
        return v;
    endfunction

    function automatic value_t random_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VW-1:0];
    endfunction

    // offer one word until taken; with pacing the sender idles between bursts
    task automatic send_word(value_t cand, value_t b1, value_t b2, bit paced);
        int gap;
        candidate   <= cand;
        base_first  <= b1;
        base_second <= b2;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_verdicts = {expected_verdicts, primality_verdict(cand, b1, b2)};
        if (paced)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 7);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // sender stays quiet until every owed verdict has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // zero, one, two and even candidates
    task automatic test_trivial_candidates();
        send_word('0, 63'd2, 63'd3, 1'b1);
        send_word(63'd1, 63'd1, 63'd1, 1'b1);
        send_word(63'd2, random_value(), random_value(), 1'b1);
        send_word(63'd4, 63'd3, 63'd3, 1'b1);
        send_word(EVEN_TOP, ALL_ONES, ALL_ONES, 1'b1);
    endtask

    // small candidates and 2^61-1 with witnesses that are zero, one or p-1 mod p
    task automatic test_special_bases();
        send_word(63'd3, 63'd1, 63'd2, 1'b1);
        send_word(63'd3, 63'd0, 63'd2, 1'b1);
        send_word(63'd3, 63'd2, 63'd3, 1'b1);
        send_word(63'd5, 63'd4, 63'd6, 1'b1);
        send_word(MERSENNE_61, MERSENNE_61 - 63'd1, 63'd1, 1'b1);
        send_word(MERSENNE_61, 63'd2, MERSENNE_61, 1'b1);
        send_word(MERSENNE_61, MERSENNE_61 + 63'd1, ALL_ONES, 1'b1);
    endtask

    // large primes, the odd maximum and strong pseudoprimes
    task automatic test_primes_and_pseudoprimes();
        send_word(MERSENNE_61, 63'd2, 63'd3, 1'b1);
        send_word(TOP_PRIME, ALL_ONES, EVEN_TOP, 1'b1);
        send_word(TOP_PRIME, random_value(), random_value(), 1'b1);
        send_word(ALL_ONES, 63'd2, 63'd3, 1'b1);
        send_word(63'd561, 63'd2, 63'd5, 1'b1);
        send_word(63'd2047, 63'd2, 63'd3, 1'b1);
        send_word(63'd3215031751, 63'd2, 63'd3, 1'b1);
        send_word(63'd25326001, 63'd3, 63'd5, 1'b1);
        send_word(63'd97, random_value(), random_value(), 1'b1);
    endtask

    // receiver holds off while quick words keep coming, so the input stalls
    task automatic test_backpressure();
        wait_results_done();
        holdoff_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_word(value_t'(2 * $urandom_range(0, 40)), random_value(),
                      random_value(), 1'b0);
        wait_results_done();
    endtask

    // mostly odd candidates, many of them prime, with some noise words
    task automatic test_random_words();
        int     sel;
        int     width;
        int     tries;
        value_t cand;
        value_t b1;
        value_t b2;
        for (int n = 0; n < 70; n++)
        begin
            sel = $urandom_range(0, 99);
            width = ($urandom_range(0, 3) == 0) ? $urandom_range(25, VW) : $urandom_range(4, 24);
            b1 = random_value();
            b2 = random_value();
            if (sel < 10)
            begin
                // noise: even values and the tiny ones
                cand = random_value() >> $urandom_range(0, VW - 1);
                if ($urandom_range(0, 2) != 0)
                    cand[0] = 1'b0;
            end
            else if (sel < 55)
            begin
                // search for a prime so that full rounds get exercised
                tries = 0;
                do
                begin
                    cand = random_odd(width);
                    tries++;
                end
                while (!primality_verdict(cand, 63'd2, 63'd3) && tries < 2000);
            end
            else
            begin
                cand = random_odd($urandom_range(2, VW));
                if (sel >= 90)
                begin
                    case ($urandom_range(0, 3))
                        0: b1 = cand;
                        1: b1 = 63'd1;
                        2: b1 = cand - 63'd1;
                        default: b2 = cand + 63'd1;
                    endcase
                end
            end
            send_word(cand, b1, b2, 1'b1);
        end
    endtask

    // receiver stall pattern, with a counted hold-off on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0)
            begin
                out_stall <= 1'b1;
                holdoff_cycles--;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 400);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // compare each taken result word with the oldest owed verdict
    initial
    begin
        bit want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    verdict_errors++;
                    if (verdict_errors <= 10)
                        $display("unexpected result word: is_probable_prime=%b",
                                 is_probable_prime);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (is_probable_prime !== want)
                    begin
                        verdict_errors++;
                        if (verdict_errors <= 10)
                            $display("is_probable_prime mismatch: expected %b, got %b",
                                     want, is_probable_prime);
                    end
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #200000000;
        $display("miller_rabin_primality_test: FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_trivial_candidates();
        test_special_bases();
        test_primes_and_pseudoprimes();
        test_backpressure();
        test_random_words();
        wait_results_done();
        repeat (100) @(posedge clk);
        if (verdict_errors == 0 && expected_verdicts.size() == 0)
            $display("miller_rabin_primality_test: PASS");
        else
            $display("miller_rabin_primality_test: FAIL");
        $finish;
    end

endmodule
